@@ hdl/klt_pkg.sv @@
package klt_pkg;

	localparam int CAPACITY = 16;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;
	localparam logic [1:0] CMD_LIST   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// Where the entry fields of a result come from.
	localparam logic [1:0] SRC_ZERO = 2'd0;
	localparam logic [1:0] SRC_ITEM = 2'd1;
	localparam logic [1:0] SRC_RD   = 2'd2;
	localparam logic [1:0] SRC_HOLD = 2'd3;

	typedef struct packed {
		logic [1:0]         command;
		logic [63:0]        item_name;
		logic [63:0]        item_kind;
		logic signed [31:0] item_quantity;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [63:0]        entry_name;
		logic [63:0]        entry_kind;
		logic signed [31:0] entry_quantity;
		logic [3:0]         position;
		logic [4:0]         comparisons;
		logic [4:0]         occupancy;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [63:0]        name;
		logic [63:0]        kind;
		logic signed [31:0] quantity;
	} entry_t;

	typedef struct packed {
		logic              load_item;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              wr_from_item;
		logic              hold_en;
		logic              res_en;
		logic [1:0]        res_src;
		logic [1:0]        res_status;
		logic [3:0]        res_pos;
		logic [4:0]        res_cmp;
		logic [4:0]        res_occ;
		logic              res_last;
	} dp_cmd_t;

	typedef struct packed {
		logic       match;
		logic [1:0] command;
	} dp_stat_t;

endpackage

@@ hdl/klt_dp.sv @@
module klt_dp import klt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output logic     strobe,
	output result_t  result
);

	entry_t   mem [CAPACITY];
	in_item_t item_q;
	entry_t   rd_q;
	entry_t   hold_q;
	logic [3:0] hold_pos_q;
	entry_t   wr_data;
	entry_t   src_entry;
	logic     strobe_q;
	result_t  result_q;

	assign wr_data = cmd.wr_from_item ?
		entry_t'{item_q.item_name, item_q.item_kind, item_q.item_quantity} : rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[cmd.rd_addr];
		end
		if (cmd.load_item) begin
			item_q <= item;
		end
		if (cmd.hold_en) begin
			hold_q     <= rd_q;
			hold_pos_q <= cmd.res_pos;
		end
	end

	always_comb begin
		case (cmd.res_src)
			SRC_ITEM: src_entry = entry_t'{item_q.item_name, item_q.item_kind,
				item_q.item_quantity};
			SRC_RD:   src_entry = rd_q;
			SRC_HOLD: src_entry = hold_q;
			default:  src_entry = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.res_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_en) begin
			result_q.status         <= cmd.res_status;
			result_q.entry_name     <= src_entry.name;
			result_q.entry_kind     <= src_entry.kind;
			result_q.entry_quantity <= src_entry.quantity;
			result_q.position       <= (cmd.res_src == SRC_HOLD) ? hold_pos_q : cmd.res_pos;
			result_q.comparisons    <= cmd.res_cmp;
			result_q.occupancy      <= cmd.res_occ;
			result_q.last           <= cmd.res_last;
		end
	end

	assign stat.match   = (rd_q.name == item_q.item_name);
	assign stat.command = item_q.command;
	assign strobe       = strobe_q;
	assign result       = result_q;

endmodule

@@ hdl/klt_ctrl.sv @@
module klt_ctrl import klt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_RMFIN = 3'd4;
	localparam logic [2:0] S_LIST  = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_p1, idx_p2, count_p1, count_m1;
	logic             at_last;

	assign idx_p1   = idx_q + CNT_W'(1);
	assign idx_p2   = idx_q + CNT_W'(2);
	assign count_p1 = count_q + CNT_W'(1);
	assign count_m1 = count_q - CNT_W'(1);
	assign at_last  = (idx_p1 == count_q);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		count_d = count_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load_item = start;
				if (start) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				cmd.res_last = 1'b1;
				cmd.res_occ  = 5'(count_q);
				state_d      = S_IDLE;
				case (stat.command)
					CMD_INSERT: begin
						cmd.res_en  = 1'b1;
						cmd.res_src = SRC_ITEM;
						if (count_q == CAP_CNT) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.wr_en        = 1'b1;
							cmd.wr_addr      = count_q[ADDR_W-1:0];
							cmd.wr_from_item = 1'b1;
							cmd.res_status   = ST_OK;
							cmd.res_pos      = 4'(count_q);
							cmd.res_occ      = 5'(count_p1);
							count_d          = count_p1;
						end
					end
					CMD_REMOVE, CMD_SEARCH: begin
						if (count_q == '0) begin
							cmd.res_en     = 1'b1;
							cmd.res_status = ST_NOT_FOUND;
						end else begin
							cmd.rd_en = 1'b1;
							idx_d     = '0;
							state_d   = S_SCAN;
						end
					end
					CMD_LIST: begin
						if (count_q == '0) begin
							cmd.res_en     = 1'b1;
							cmd.res_status = ST_EMPTY;
						end else begin
							cmd.rd_en = 1'b1;
							idx_d     = '0;
							state_d   = S_LIST;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SCAN: begin
				cmd.res_last = 1'b1;
				cmd.res_occ  = 5'(count_q);
				cmd.res_pos  = 4'(idx_q);
				if (stat.match) begin
					if (stat.command == CMD_SEARCH) begin
						cmd.res_en     = 1'b1;
						cmd.res_src    = SRC_RD;
						cmd.res_status = ST_OK;
						cmd.res_cmp    = 5'(idx_p1);
						state_d        = S_IDLE;
					end else begin
						cmd.hold_en = 1'b1;
						if (at_last) begin
							state_d = S_RMFIN;
						end else begin
							cmd.rd_en   = 1'b1;
							cmd.rd_addr = idx_p1[ADDR_W-1:0];
							state_d     = S_SHIFT;
						end
					end
				end else if (at_last) begin
					cmd.res_en     = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					cmd.res_pos    = '0;
					cmd.res_cmp    = (stat.command == CMD_SEARCH) ? 5'(count_q) : 5'd0;
					state_d        = S_IDLE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = idx_p1[ADDR_W-1:0];
					idx_d       = idx_p1;
				end
			end
			S_SHIFT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = idx_q[ADDR_W-1:0];
				if (idx_p2 == count_q) begin
					state_d = S_RMFIN;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = idx_p2[ADDR_W-1:0];
					idx_d       = idx_p1;
				end
			end
			S_RMFIN: begin
				cmd.res_en     = 1'b1;
				cmd.res_src    = SRC_HOLD;
				cmd.res_status = ST_OK;
				cmd.res_occ    = 5'(count_m1);
				cmd.res_last   = 1'b1;
				count_d        = count_m1;
				state_d        = S_IDLE;
			end
			S_LIST: begin
				cmd.res_en     = 1'b1;
				cmd.res_src    = SRC_RD;
				cmd.res_status = ST_OK;
				cmd.res_pos    = 4'(idx_q);
				cmd.res_occ    = 5'(count_q);
				cmd.res_last   = at_last;
				if (at_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = idx_p1[ADDR_W-1:0];
					idx_d       = idx_p1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			count_q <= count_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count above capacity");

	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> idx_p1 < count_q)
		else $error("shift reads beyond the last entry");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> state_q == S_DISP)
		else $error("accepted transaction not dispatched");

	a_partial_list: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_en && !cmd.res_last) |-> state_q == S_LIST)
		else $error("non-final result outside a list walk");

endmodule

@@ hdl/keyed_list_table_top.sv @@
// Channel    Handshake              Payload
// ---------  ---------------------  -----------------------------------------
// command    start, busy            item   (in_item_t: command, name, kind, qty)
// result     strobe                 result (result_t: status ... last)
//
// A transaction is accepted on a rising edge with start high and busy low.
// Busy then stays high while the transaction is sequenced, and the final
// result is strobed in the cycle after busy's last high cycle. Insert is
// handled in the dispatch state alone. A search dispatches, then scans entries
// in order up to the hit, or all of them on a miss. A remove walks the same
// way; on a hit it then shifts each later entry down and finishes the remove.
// List dispatches, then walks every entry in order.
// The walks step through the entry memory: one entry read and one write per cycle.
// Each result is shown for exactly one cycle under strobe; the receiver cannot
// stall, so no back-pressure exists. Reset clears the entry count, index,
// state and strobe; entries are undefined until written, never read past count.
module keyed_list_table_top import klt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t item,
	output logic     busy,
	output logic     strobe,
	output result_t  result
);

	// The controller sequences the scan, shift and list walks; the datapath
	// holds the entry memory, the latched transaction and the result register.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	klt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	klt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.strobe (strobe),
		.result (result)
	);

endmodule
